/* design/lru_page_tracking_cache_core_defines.svh */
// ----------------------------------------------------------------------------
// LRU page tracking cache: assertion macros
// Shared macro forms for the concurrent checks on the cache core.
// ----------------------------------------------------------------------------
`ifndef LRU_PAGE_TRACKING_CACHE_CORE_DEFINES_SVH
`define LRU_PAGE_TRACKING_CACHE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LRUPC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LRUPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/lrupc_pkg.sv */
// ----------------------------------------------------------------------------
// LRU page tracking cache package
// Constants, controller state type and controller/datapath interface structs.
// ----------------------------------------------------------------------------
`default_nettype none

package lrupc_pkg;

  localparam int PAGE_SHIFT       = 11;
  localparam int EVICT_PAGE_W     = 37;
  localparam int OWNER_W          = 8;
  localparam int CAP_W            = 6;
  localparam int MAX_ENTRIES_DEF  = 32;
  localparam int ADDRESS_BITS_DEF = 48;

  localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SELECT = 3'b010,
    ST_UPDATE = 3'b100
  } state_t;

  typedef struct packed {
    logic capture;
    logic select;
    logic update;
  } cmd_t;

  typedef struct packed {
    logic out_room;
  } status_t;

endpackage

`default_nettype wire

/* design/lrupc_ctrl.sv */
// ----------------------------------------------------------------------------
// LRU page tracking cache controller
// Sequences one request through lookup, select and update.
// ----------------------------------------------------------------------------
`default_nettype none

module lrupc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire lrupc_pkg::status_t status,
  output lrupc_pkg::cmd_t         cmd,
  output logic                    in_stall
);
  import lrupc_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt   = state_r;
    cmd.capture = 1'b0;
    cmd.select  = 1'b0;
    cmd.update  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_SELECT;
        end
      end
      ST_SELECT: begin
        cmd.select = 1'b1;
        state_nxt  = ST_UPDATE;
      end
      ST_UPDATE: begin
        // The update and the result write happen together, so wait for room.
        if (status.out_room) begin
          cmd.update = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_stall = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

/* design/lrupc_datapath.sv */
// ----------------------------------------------------------------------------
// LRU page tracking cache datapath
// Entry cells with page tags and ages, capacity register and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lrupc_datapath #(
  parameter int MAX_ENTRIES  = lrupc_pkg::MAX_ENTRIES_DEF,
  parameter int ADDRESS_BITS = lrupc_pkg::ADDRESS_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire lrupc_pkg::cmd_t                      cmd,
  output lrupc_pkg::status_t                        status,
  input  wire logic                                 cfg_wr_en,
  input  wire logic [lrupc_pkg::CAP_W-1:0]          cfg_capacity,
  input  wire logic [ADDRESS_BITS-1:0]              in_access_address,
  input  wire logic [lrupc_pkg::OWNER_W-1:0]        in_owner_id,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic                                      out_hit,
  output logic                                      out_evict_valid,
  output logic [lrupc_pkg::EVICT_PAGE_W-1:0]        out_evict_page,
  output logic [lrupc_pkg::OWNER_W-1:0]             out_evict_owner
);
  import lrupc_pkg::*;

  localparam int PAGE_W = ADDRESS_BITS - PAGE_SHIFT;
  localparam int AGE_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int OCC_W  = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W  = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  // Entry cells. Valid entries always form the prefix [0, occupancy).
  logic [PAGE_W-1:0] page_r [MAX_ENTRIES];
  logic [AGE_W-1:0]  age_r  [MAX_ENTRIES];
  logic [OCC_W-1:0]  occ_r;
  logic [CAP_W-1:0]  cap_r;

  // Request held across select and update.
  logic [PAGE_W-1:0]      req_page_r;
  logic [OWNER_W-1:0]     req_owner_r;
  logic [MAX_ENTRIES-1:0] match_r;
  logic [MAX_ENTRIES-1:0] victim_r;
  logic                   hit_r;
  logic                   evict_r;
  logic [AGE_W-1:0]       sel_age_r;
  logic [PAGE_W-1:0]      sel_page_r;

  logic                    out_valid_r;
  logic                    out_hit_r;
  logic                    out_evict_valid_r;
  logic [EVICT_PAGE_W-1:0] out_evict_page_r;
  logic [OWNER_W-1:0]      out_evict_owner_r;

  logic [PAGE_W-1:0]      in_page;
  logic [AGE_W-1:0]       oldest_age;
  logic [MAX_ENTRIES-1:0] ent_valid;
  logic [MAX_ENTRIES-1:0] cap_match;
  logic [MAX_ENTRIES-1:0] cap_victim;
  logic [MAX_ENTRIES-1:0] ins_slot;
  logic [AGE_W-1:0]       sel_age;
  logic [PAGE_W-1:0]      sel_page;
  logic [CMP_W-1:0]       cap_ext;
  logic [CMP_W-1:0]       max_ext;
  logic [CMP_W-1:0]       eff_cap;
  logic                   full;

  assign in_page    = in_access_address[ADDRESS_BITS-1:PAGE_SHIFT];
  assign oldest_age = AGE_W'(occ_r - OCC_W'(1));

  // Capacity zero behaves as one; anything above the built size is clamped.
  assign cap_ext = CMP_W'(cap_r);
  assign max_ext = CMP_W'(MAX_ENTRIES);
  always_comb begin
    priority if (cap_r == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > max_ext) begin
      eff_cap = max_ext;
    end else begin
      eff_cap = cap_ext;
    end
  end
  assign full = (CMP_W'(occ_r) >= eff_cap);

  // Per-cell tag compare and oldest-age detect, all in parallel.
  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      ent_valid[i]  = (OCC_W'(i) < occ_r);
      cap_match[i]  = ent_valid[i] && (page_r[i] == in_page);
      cap_victim[i] = ent_valid[i] && (age_r[i] == oldest_age);
      ins_slot[i]   = evict_r ? victim_r[i] : (OCC_W'(i) == occ_r);
    end
  end

  // One-hot selects of the hit age and the victim page.
  always_comb begin
    sel_age  = '0;
    sel_page = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      sel_age  = sel_age  | (age_r[i]  & {AGE_W{match_r[i]}});
      sel_page = sel_page | (page_r[i] & {PAGE_W{victim_r[i]}});
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_page_r  <= in_page;
      req_owner_r <= in_owner_id;
      match_r     <= cap_match;
      victim_r    <= cap_victim;
      hit_r       <= |cap_match;
      evict_r     <= !(|cap_match) && full;
    end
    if (cmd.select) begin
      sel_age_r  <= sel_age;
      sel_page_r <= sel_page;
    end
    if (cmd.update) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (hit_r) begin
          if (match_r[i]) begin
            age_r[i] <= '0;
          end else if (ent_valid[i] && (age_r[i] < sel_age_r)) begin
            age_r[i] <= age_r[i] + AGE_W'(1);
          end
        end else begin
          // On a miss the victim slot, or the first free slot, takes the page.
          if (ins_slot[i]) begin
            page_r[i] <= req_page_r;
            age_r[i]  <= '0;
          end else if (ent_valid[i]) begin
            age_r[i] <= age_r[i] + AGE_W'(1);
          end
        end
      end
      out_hit_r         <= hit_r;
      out_evict_valid_r <= evict_r;
      out_evict_page_r  <= evict_r ? EVICT_PAGE_W'(sel_page_r) : '0;
      out_evict_owner_r <= evict_r ? req_owner_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_capacity;
      end
      if (cmd.update && !hit_r && !evict_r) begin
        occ_r <= occ_r + OCC_W'(1);
      end
      if (cmd.update) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign status.out_room = !out_valid_r || !out_stall;

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_evict_valid = out_evict_valid_r;
  assign out_evict_page  = out_evict_page_r;
  assign out_evict_owner = out_evict_owner_r;

endmodule

`default_nettype wire

/* design/lru_page_tracking_cache_core.sv */
// ----------------------------------------------------------------------------
// LRU page tracking cache core
// Fully associative cache of page numbers (address bits 11 and up) with
// true LRU ordering. Every request returns one result: hit, or miss with an
// optional eviction of the least recently used page, reported with the
// requester's owner id. The tags of all entry cells are compared in parallel
// at the edge that accepts a request. The next cycle does a one-hot select of
// the hit age and victim page. The update step then waits for room in the
// result register, updates the ages, inserts the page and loads the result
// register. A new request is not accepted until that update is done. The
// next request is taken once the result has been written, even while that
// result still waits on out_stall. The update of that next request then
// waits until the waiting result has been taken. The capacity register
// limits how many entries are used; zero counts as one and values above
// MAX_ENTRIES are clamped. Write it only while no request is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_page_tracking_cache_core #(
  parameter int MAX_ENTRIES  = lrupc_pkg::MAX_ENTRIES_DEF,
  parameter int ADDRESS_BITS = lrupc_pkg::ADDRESS_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_wr_en,
  input  wire logic [lrupc_pkg::CAP_W-1:0]          cfg_capacity,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [ADDRESS_BITS-1:0]              in_access_address,
  input  wire logic [lrupc_pkg::OWNER_W-1:0]        in_owner_id,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic                                      out_hit,
  output logic                                      out_evict_valid,
  output logic [lrupc_pkg::EVICT_PAGE_W-1:0]        out_evict_page,
  output logic [lrupc_pkg::OWNER_W-1:0]             out_evict_owner
);
  import lrupc_pkg::*;

  cmd_t    cmd;
  status_t status;

  lrupc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .status   (status),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  lrupc_datapath #(
    .MAX_ENTRIES  (MAX_ENTRIES),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_capacity      (cfg_capacity),
    .in_access_address (in_access_address),
    .in_owner_id       (in_owner_id),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_hit           (out_hit),
    .out_evict_valid   (out_evict_valid),
    .out_evict_page    (out_evict_page),
    .out_evict_owner   (out_evict_owner)
  );

endmodule

`default_nettype wire

/* design/lrupc_checker.sv */
// ----------------------------------------------------------------------------
// LRU page tracking cache checker
// Port-level checks on the cache core, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none
`include "lru_page_tracking_cache_core_defines.svh"

module lrupc_checker (
  input wire logic                                 clk,
  input wire logic                                 rst_n,
  input wire logic                                 in_valid,
  input wire logic                                 in_stall,
  input wire logic                                 out_valid,
  input wire logic                                 out_stall,
  input wire logic                                 out_hit,
  input wire logic                                 out_evict_valid,
  input wire logic [lrupc_pkg::EVICT_PAGE_W-1:0]   out_evict_page,
  input wire logic [lrupc_pkg::OWNER_W-1:0]        out_evict_owner
);

  // A hit never evicts.
  `LRUPC_ASSERT_NOW(a_hit_no_evict, clk, rst_n, out_valid, !(out_hit && out_evict_valid), "hit with eviction")

  // Without an eviction the evicted page and owner read as zero.
  `LRUPC_ASSERT_NOW(a_no_evict_zero, clk, rst_n, out_valid && !out_evict_valid, (out_evict_page == '0) && (out_evict_owner == '0), "stale eviction fields")

  // Only one request is in flight, so an accept closes the input at once.
  `LRUPC_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && !in_stall, in_stall, "second request taken while busy")

  // A stalled result holds.
  `LRUPC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_hit) && $stable(out_evict_valid) && $stable(out_evict_page) && $stable(out_evict_owner), "stalled result changed")

endmodule

bind lru_page_tracking_cache_core lrupc_checker u_lrupc_checker (.*);

`default_nettype wire

/* test/tb_lru_page_tracking_cache_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LRU page tracking cache core testbench
// Sends page access requests through the valid/stall input channel, predicts
// hit, eviction, evicted page and owner with a cycle-free LRU model, and
// checks every result in order while both channels idle at random. The
// capacity register is swept over several settings, including zero, one,
// the built size and values above it.
// ----------------------------------------------------------------------------

module tb_lru_page_tracking_cache_core;
  import lrupc_pkg::*;

  localparam int ADDR_W      = ADDRESS_BITS_DEF;
  localparam int LINES       = MAX_ENTRIES_DEF;
  localparam int CYCLE_LIMIT = 500000;
  localparam int PRINT_LIMIT = 50;

  typedef struct packed {
    logic                    hit;
    logic                    evict_valid;
    logic [EVICT_PAGE_W-1:0] evict_page;
    logic [OWNER_W-1:0]      evict_owner;
  } access_result_t;

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_wr_en;
  logic [CAP_W-1:0]        cfg_capacity;
  logic                    in_valid;
  logic                    in_stall;
  logic [ADDR_W-1:0]       in_access_address;
  logic [OWNER_W-1:0]      in_owner_id;
  logic                    out_valid;
  logic                    out_stall;
  logic                    out_hit;
  logic                    out_evict_valid;
  logic [EVICT_PAGE_W-1:0] out_evict_page;
  logic [OWNER_W-1:0]      out_evict_owner;

  // Predicted cache contents.
  logic                    line_valid [LINES];
  logic [EVICT_PAGE_W-1:0] line_page [LINES];
  int                      line_age [LINES];
  int                      lines_held;
  logic [CAP_W-1:0]        capacity_setting;

  access_result_t          pending_results[$];
  logic [EVICT_PAGE_W-1:0] page_pool [64];
  int                      mismatches;
  int                      cycle_count;
  bit                      steady;

  lru_page_tracking_cache_core i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_capacity      (cfg_capacity),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_access_address (in_access_address),
    .in_owner_id       (in_owner_id),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_hit           (out_hit),
    .out_evict_valid   (out_evict_valid),
    .out_evict_page    (out_evict_page),
    .out_evict_owner   (out_evict_owner)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  function automatic int usable_lines();
    if (capacity_setting == 0) return 1;
    if (capacity_setting > LINES) return LINES;
    return capacity_setting;
  endfunction

  // Updates the predicted cache for one access and returns its result.
  function automatic access_result_t lookup_page(logic [ADDR_W-1:0] addr,
                                                 logic [OWNER_W-1:0] owner);
    access_result_t          r;
    logic [EVICT_PAGE_W-1:0] page;
    int                      found;
    int                      victim;
    int                      hit_age;
    page  = addr[ADDR_W-1:PAGE_SHIFT];
    r     = '0;
    found = -1;
    for (int i = 0; i < LINES; i++) begin
      if (found < 0 && line_valid[i] && line_page[i] == page) found = i;
    end
    if (found >= 0) begin
      hit_age = line_age[found];
      for (int i = 0; i < LINES; i++) begin
        if (line_valid[i] && line_age[i] < hit_age) line_age[i]++;
      end
      line_age[found] = 0;
      r.hit = 1'b1;
      return r;
    end
    if (lines_held >= usable_lines()) begin
      victim = -1;
      for (int i = 0; i < LINES; i++) begin
        if (line_valid[i] && (victim < 0 || line_age[i] > line_age[victim])) victim = i;
      end
      if (victim >= 0) begin
        line_valid[victim] = 1'b0;
        if (lines_held > 0) lines_held--;
        r.evict_valid = 1'b1;
        r.evict_page  = line_page[victim];
        r.evict_owner = owner;
      end
    end
    for (int i = 0; i < LINES; i++) begin
      if (line_valid[i]) line_age[i]++;
    end
    found = -1;
    for (int i = 0; i < LINES; i++) begin
      if (found < 0 && !line_valid[i]) found = i;
    end
    if (found >= 0) begin
      line_valid[found] = 1'b1;
      line_page[found]  = page;
      line_age[found]   = 0;
      lines_held++;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) begin
      $display("mismatch in %s at cycle %0d: got %0h, expected %0h",
               what, cycle_count, got, want);
    end
  endtask

  // Sends one request and records its expected result once it is taken.
  task automatic send_access(input logic [ADDR_W-1:0] addr, input logic [OWNER_W-1:0] owner);
    int             gap;
    access_result_t expected;
    gap = steady ? 0 : idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_access_address <= addr;
    in_owner_id       <= owner;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected        = lookup_page(addr, owner);
    pending_results = {pending_results, expected};
  endtask

  task automatic send_page(input logic [EVICT_PAGE_W-1:0] page, input logic [OWNER_W-1:0] owner);
    send_access({page, 11'($urandom_range(0, 2047))}, owner);
  endtask

  // Waits until every result is back, then lets the pipeline settle.
  task automatic drain_requests();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] value);
    drain_requests();
    cfg_wr_en    <= 1'b1;
    cfg_capacity <= value;
    @(posedge clk);
    cfg_wr_en        <= 1'b0;
    capacity_setting  = value;
  endtask

  // Reset capacity, page boundaries and address extremes.
  task automatic test_reset_state();
    send_access('0, 8'h00);
    send_access('1, 8'hFF);
    send_access(48'h0000_0000_07FF, 8'h5A);
    send_access(48'h0000_0000_0800, 8'hA5);
    send_access('1, 8'h01);
    send_access(48'h0000_0000_0000, 8'h80);
    send_access(48'h0000_0000_0801, 8'h7F);
  endtask

  // Shrinking below the fill level evicts one line per miss.
  task automatic test_capacity_one();
    set_capacity(6'd1);
    send_access(48'h0000_0000_2800, 8'hFF);
    send_access(48'h8000_0000_0000, 8'h00);
    send_access(48'h8000_0000_07FF, 8'h33);
    send_access(48'h0000_0000_0000, 8'hFF);
  endtask

  // Zero is handled as a capacity of one.
  task automatic test_capacity_zero();
    set_capacity(6'd0);
    send_access(48'h1234_5678_9ABC, 8'h11);
    send_access(48'h1234_5678_9800, 8'h22);
    send_access(48'hFFFF_FFFF_F800, 8'hFF);
  endtask

  // Least recent order at capacity two: a hit refreshes, a miss drops the oldest.
  task automatic test_lru_order();
    set_capacity(6'd2);
    send_access(48'h0000_0001_0000, 8'h01);
    send_access(48'hFFFF_FFFF_F800, 8'h02);
    send_access(48'h0000_0002_0000, 8'h03);
    send_access(48'h0000_0001_0000, 8'h04);
    send_access(48'h0000_0002_07FF, 8'h05);
    send_access(48'h5555_5555_5555, 8'hAA);
  endtask

  // Random traffic over a pool of pages sized around the capacity, with a
  // share of fully random pages.
  task automatic test_random_traffic(input logic [CAP_W-1:0] cap, input int count,
                                     input int pool_size);
    logic [EVICT_PAGE_W-1:0] page;
    set_capacity(cap);
    for (int i = 0; i < pool_size; i++) page_pool[i] = EVICT_PAGE_W'({$urandom, $urandom});
    for (int k = 0; k < count; k++) begin
      steady = ((k / 40) % 4) == 3;
      if ($urandom_range(0, 99) < 85) page = page_pool[$urandom_range(0, pool_size - 1)];
      else page = EVICT_PAGE_W'({$urandom, $urandom});
      send_page(page, 8'($urandom));
    end
    steady = 1'b0;
  endtask

  always @(posedge clk) begin : check_results
    access_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request waiting", 64'(out_hit), 64'd0);
      end else begin
        want = pending_results.pop_front();
        if (out_hit !== want.hit) report_mismatch("hit", 64'(out_hit), 64'(want.hit));
        if (out_evict_valid !== want.evict_valid)
          report_mismatch("evict_valid", 64'(out_evict_valid), 64'(want.evict_valid));
        if (out_evict_page !== want.evict_page)
          report_mismatch("evict_page", 64'(out_evict_page), 64'(want.evict_page));
        if (out_evict_owner !== want.evict_owner)
          report_mismatch("evict_owner", 64'(out_evict_owner), 64'(want.evict_owner));
      end
    end
  end

  initial begin : stall_results
    int hold;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      hold = steady ? 0 : idle_gap();
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : run_tests
    rst_n             <= 1'b0;
    cfg_wr_en         <= 1'b0;
    cfg_capacity      <= CAP_RESET;
    in_valid          <= 1'b0;
    in_access_address <= '0;
    in_owner_id       <= '0;
    mismatches        = 0;
    cycle_count       = 0;
    steady            = 1'b0;
    lines_held        = 0;
    capacity_setting  = CAP_RESET;
    for (int i = 0; i < LINES; i++) begin
      line_valid[i] = 1'b0;
      line_page[i]  = '0;
      line_age[i]   = 0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_capacity_one();
    test_capacity_zero();
    test_lru_order();
    test_random_traffic(6'd32, 200, 48);
    test_random_traffic(6'd63, 150, 40);
    test_random_traffic(6'd4, 150, 8);
    test_random_traffic(6'd1, 100, 3);
    test_random_traffic(6'd0, 100, 3);
    test_random_traffic(6'd16, 200, 24);
    test_random_traffic(6'd40, 150, 40);
    test_random_traffic(6'd2, 100, 4);
    test_random_traffic(6'd32, 200, 64);

    drain_requests();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* lru_page_tracking_cache_core.f */
+incdir+design
design/lrupc_pkg.sv
design/lrupc_ctrl.sv
design/lrupc_datapath.sv
design/lru_page_tracking_cache_core.sv
design/lrupc_checker.sv
test/tb_lru_page_tracking_cache_core.sv
